@@ design/psda_pkg.sv @@
// shared types, constants and tables for the polarization stokes block
// no dependencies
package psda_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int ATAN_LEN   = 24;
  localparam int CORDIC_N   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int SQRT_STEPS = 29;
  localparam int DIV_BITS   = 16;

  // pipeline timing, in register stages after acceptance
  localparam int LAT_ROOT = 2 + SQRT_STEPS;
  localparam int LAT_Q    = LAT_ROOT + DIV_BITS;
  localparam int D_S0     = LAT_ROOT - 1;
  localparam int D_INT    = LAT_Q - 1;
  localparam int D_ANG    = LAT_Q - (3 + CORDIC_N);

  localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 1);
  localparam logic [15:0] NARROW_MASK = 16'h00ff;

  localparam logic signed [26:0] DEG180_Z   = 27'sd11796480;
  localparam logic signed [17:0] AOLP_LIMIT = 18'sd23040;

  typedef struct packed {
    logic [15:0] sample_pol90;
    logic [15:0] sample_pol45;
    logic [15:0] sample_pol135;
    logic [15:0] sample_pol0;
  } in_word_t;

  typedef struct packed {
    logic [17:0]        intensity;
    logic [15:0]        dolp;
    logic signed [15:0] aolp;
  } out_word_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

  // atan(2^-i) in degrees * 65536
  function automatic logic signed [26:0] atan_q16(input int i);
    logic signed [26:0] v;
    case (i)
      0:  v = 27'sd2949120;
      1:  v = 27'sd1740967;
      2:  v = 27'sd919879;
      3:  v = 27'sd466945;
      4:  v = 27'sd234379;
      5:  v = 27'sd117306;
      6:  v = 27'sd58666;
      7:  v = 27'sd29335;
      8:  v = 27'sd14668;
      9:  v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1833;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/polarization_stokes_dolp_aolp.sv @@
// polarization superpixel analyzer: intensity, dolp and aolp per 2x2 superpixel
// one word per cycle from accepted word to result word while the result is not stalled
// throughput is set by the fully pipelined sqrt, divider and cordic
// a stalled result freezes the whole pipeline; nothing is lost or repeated
// synchronous active-low reset clears valid bits and the narrow_r register
module polarization_stokes_dolp_aolp import psda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  pipe_ctl_t ctl;
  logic      narrow_r;
  logic      vpipe_r [LAT_Q];
  logic      out_valid_r;
  out_word_t out_data_r;

  // pipeline advances when the output register is free or being taken
  assign ctl.en   = !out_valid_r || !out_stall;
  assign in_stall = !ctl.en;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r <= 1'b0;
    end else if (cfg_we) begin
      narrow_r <= cfg_wdata;
    end
  end

  // stage a: mask samples and form stokes terms
  logic [15:0] mask, p90, p45, p135, p0;
  assign mask = narrow_r ? NARROW_MASK : SAMPLE_MASK;
  assign p90  = in_data.sample_pol90  & mask;
  assign p45  = in_data.sample_pol45  & mask;
  assign p135 = in_data.sample_pol135 & mask;
  assign p0   = in_data.sample_pol0   & mask;

  logic [17:0]        a_int_r;
  logic [16:0]        a_s0_r;
  logic signed [16:0] a_s1_r, a_s2_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      a_int_r <= {2'd0, p0} + {2'd0, p45} + {2'd0, p90} + {2'd0, p135};
      a_s0_r  <= {1'b0, p0} + {1'b0, p90};
      a_s1_r  <= signed'({1'b0, p0}) - signed'({1'b0, p90});
      a_s2_r  <= signed'({1'b0, p45}) - signed'({1'b0, p135});
    end
  end

  // stage b: squares
  logic signed [33:0] prod1, prod2;
  logic [31:0]        b_sq1_r, b_sq2_r;
  assign prod1 = a_s1_r * a_s1_r;
  assign prod2 = a_s2_r * a_s2_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      b_sq1_r <= prod1[31:0];
      b_sq2_r <= prod2[31:0];
    end
  end

  // magnitude, degree and angle units
  logic [28:0]        root;
  logic [15:0]        dolp;
  logic signed [15:0] aolp;
  logic [16:0]        s0d;

  psda_sqrt u_sqrt (
    .clk  (clk),
    .ctl  (ctl),
    .sq1  (b_sq1_r),
    .sq2  (b_sq2_r),
    .root (root)
  );

  psda_div u_div (
    .clk     (clk),
    .ctl     (ctl),
    .root    (root),
    .divisor (s0d),
    .dolp    (dolp)
  );

  psda_cordic u_cordic (
    .clk  (clk),
    .ctl  (ctl),
    .s1   (a_s1_r),
    .s2   (a_s2_r),
    .aolp (aolp)
  );

  // alignment delay lines
  logic [16:0]        s0_dl_r  [D_S0];
  logic [17:0]        int_dl_r [D_INT];
  logic signed [15:0] ang_dl_r [D_ANG];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s0_dl_r[0]  <= a_s0_r;
      int_dl_r[0] <= a_int_r;
      ang_dl_r[0] <= aolp;
      for (int k = 1; k < D_S0; k++) s0_dl_r[k] <= s0_dl_r[k-1];
      for (int k = 1; k < D_INT; k++) int_dl_r[k] <= int_dl_r[k-1];
      for (int k = 1; k < D_ANG; k++) ang_dl_r[k] <= ang_dl_r[k-1];
    end
  end

  // zero s0 divides by one
  assign s0d = (s0_dl_r[D_S0-1] == 17'd0) ? 17'd1 : s0_dl_r[D_S0-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT_Q; k++) vpipe_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ctl.en) begin
      vpipe_r[0] <= in_valid;
      for (int k = 1; k < LAT_Q; k++) vpipe_r[k] <= vpipe_r[k-1];
      out_valid_r <= vpipe_r[LAT_Q-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      out_data_r.intensity <= int_dl_r[D_INT-1];
      out_data_r.dolp      <= dolp;
      out_data_r.aolp      <= ang_dl_r[D_ANG-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // angle stays within half a turn
  a_aolp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.aolp <= 16'sd23040) && (out_data.aolp >= -16'sd23040))
    else $error("aolp out of range");

  // a dark superpixel has no polarization and no angle
  a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.intensity == 18'd0) |->
      (out_data.dolp == 16'd0) && (out_data.aolp == 16'sd0))
    else $error("dark superpixel gave nonzero dolp or aolp");

endmodule

@@ design/psda_sqrt.sv @@
// pipelined integer square root of (mag2 << 24), one result bit per stage
// depends on psda_pkg
module psda_sqrt import psda_pkg::*; (
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  logic [31:0] sq1,
  input  logic [31:0] sq2,
  output logic [28:0] root
);

  logic [31:0] rem_r  [SQRT_STEPS];
  logic [28:0] root_r [SQRT_STEPS];
  logic [32:0] mag_r  [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_st
    logic [31:0] rem_in, rem_sh, trial;
    logic [28:0] root_in;
    logic [32:0] mag_in;
    logic [57:0] v_in;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign mag_in  = {1'b0, sq1} + {1'b0, sq2};
    end else begin : g_rest
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign mag_in  = mag_r[i-1];
    end

    // bring down the next pair of radicand bits
    assign v_in   = {1'b0, mag_in, 24'd0};
    assign rem_sh = {rem_in[29:0], v_in[57-2*i -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        mag_r[i] <= mag_in;
        if (rem_sh >= trial) begin
          rem_r[i]  <= rem_sh - trial;
          root_r[i] <= {root_in[27:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[27:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[SQRT_STEPS-1];

endmodule

@@ design/psda_div.sv @@
// pipelined restoring divider with saturation to 16 quotient bits
// depends on psda_pkg
module psda_div import psda_pkg::*; (
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  logic [28:0] root,
  input  logic [16:0] divisor,
  output logic [15:0] dolp
);

  logic [16:0] rem_r  [DIV_BITS];
  logic [15:0] lo_r   [DIV_BITS];
  logic [16:0] d_r    [DIV_BITS];
  logic [15:0] q_r    [DIV_BITS];
  logic        sat_r  [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_st
    logic [16:0] rem_in, d_in, rem_nxt;
    logic [15:0] lo_in, q_in;
    logic        sat_in, ge;
    logic [17:0] rem_sh;

    if (k == 0) begin : g_first
      assign rem_in = {4'd0, root[28:16]};
      assign lo_in  = root[15:0];
      assign d_in   = divisor;
      assign q_in   = '0;
      // quotient would not fit in 16 bits
      assign sat_in = {4'd0, root} >= {divisor, 16'd0};
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign d_in   = d_r[k-1];
      assign q_in   = q_r[k-1];
      assign sat_in = sat_r[k-1];
    end

    assign rem_sh  = {rem_in, lo_in[DIV_BITS-1-k]};
    assign ge      = rem_sh >= {1'b0, d_in};
    assign rem_nxt = ge ? 17'(rem_sh - {1'b0, d_in}) : rem_sh[16:0];

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k] <= rem_nxt;
        lo_r[k]  <= lo_in;
        d_r[k]   <= d_in;
        q_r[k]   <= {q_in[14:0], ge};
        sat_r[k] <= sat_in;
      end
    end
  end

  assign dolp = sat_r[DIV_BITS-1] ? 16'hffff : q_r[DIV_BITS-1];

endmodule

@@ design/psda_cordic.sv @@
// pipelined vectoring cordic giving atan2(s2, s1) in degrees, signed q9.7
// depends on psda_pkg
module psda_cordic import psda_pkg::*; (
  input  logic               clk,
  input  pipe_ctl_t          ctl,
  input  logic signed [16:0] s1,
  input  logic signed [16:0] s2,
  output logic signed [15:0] aolp
);

  logic signed [27:0] x0_r, y0_r;
  logic signed [26:0] z0_r;
  logic               zero0_r, neg0_r;

  logic signed [27:0] x_r [CORDIC_N];
  logic signed [27:0] y_r [CORDIC_N];
  logic signed [26:0] z_r [CORDIC_N];
  logic               zero_r [CORDIC_N];
  logic               neg_r  [CORDIC_N];

  logic signed [15:0] aolp_r;

  // pre-rotation into the right half plane
  logic signed [27:0] xs, ys;
  assign xs = {{3{s1[16]}}, s1, 8'd0};
  assign ys = {{3{s2[16]}}, s2, 8'd0};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      zero0_r <= (s2 == 17'sd0);
      neg0_r  <= s1[16];
      if (s1[16]) begin
        x0_r <= -xs;
        y0_r <= -ys;
        z0_r <= s2[16] ? -DEG180_Z : DEG180_Z;
      end else begin
        x0_r <= xs;
        y0_r <= ys;
        z0_r <= '0;
      end
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_st
    logic signed [27:0] x_in, y_in;
    logic signed [26:0] z_in;
    logic               zero_in, neg_in;

    if (i == 0) begin : g_first
      assign x_in = x0_r;
      assign y_in = y0_r;
      assign z_in = z0_r;
      assign zero_in = zero0_r;
      assign neg_in  = neg0_r;
    end else begin : g_rest
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign zero_in = zero_r[i-1];
      assign neg_in  = neg_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        zero_r[i] <= zero_in;
        neg_r[i]  <= neg_in;
        if (!y_in[27]) begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + atan_q16(i);
        end else begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - atan_q16(i);
        end
      end
    end
  end

  // round half up to q9.7, clamp, and handle the on-axis case
  logic signed [26:0] z_rnd;
  logic signed [17:0] r;
  logic signed [17:0] r_clamp;
  assign z_rnd = z_r[CORDIC_N-1] + 27'sd256;
  assign r     = 18'(z_rnd >>> 9);

  always_comb begin
    if (r > AOLP_LIMIT) begin
      r_clamp = AOLP_LIMIT;
    end else if (r < -AOLP_LIMIT) begin
      r_clamp = -AOLP_LIMIT;
    end else begin
      r_clamp = r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (zero_r[CORDIC_N-1]) begin
        aolp_r <= neg_r[CORDIC_N-1] ? 16'(AOLP_LIMIT) : 16'sd0;
      end else begin
        aolp_r <= 16'(r_clamp);
      end
    end
  end

  assign aolp = aolp_r;

endmodule

@@ bench/tb_polarization_stokes_dolp_aolp.sv @@
// testbench for polarization_stokes_dolp_aolp: random and directed superpixels
// checked against an in-bench predictor of intensity, dolp and aolp
// depends on psda_pkg and the design top level
`timescale 1ns / 100ps

module tb_polarization_stokes_dolp_aolp;
  import psda_pkg::*;

  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES   = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  in_word_t  pixel_q[$];
  out_word_t stokes_q[$];
  bit        narrow_mode;
  int        n_errors;
  int        n_checked;
  int        n_sent;
  int        cycle_cnt;
  bit        in_burst;
  bit        in_taken;
  bit        out_hold;

  polarization_stokes_dolp_aolp uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // random gap length: none half the time, otherwise mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring cordic angle in q9.7 degrees
  function automatic logic signed [15:0] stokes_angle(longint s1, longint s2);
    longint x, y, z, dx, dy, r;
    logic signed [26:0] tbl [0:23];
    tbl = '{2949120, 1740967, 919879, 466945, 234379, 117306, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    if (s2 == 0) return (s1 < 0) ? 16'sd23040 : 16'sd0;
    x = s1 * 256;
    y = s2 * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + tbl[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - tbl[i];
      end
    end
    r = shr_floor(z + 256, 9);
    if (r > 23040) r = 23040;
    if (r < -23040) r = -23040;
    return 16'(r);
  endfunction

  function automatic out_word_t stokes_predict(in_word_t px);
    out_word_t o;
    logic [15:0] m;
    longint p90, p45, p135, p0, s0, s1, s2;
    longint unsigned mag2, q;
    m = narrow_mode ? NARROW_MASK : SAMPLE_MASK;
    p90 = px.sample_pol90 & m;
    p45 = px.sample_pol45 & m;
    p135 = px.sample_pol135 & m;
    p0 = px.sample_pol0 & m;
    s0 = p0 + p90;
    s1 = p0 - p90;
    s2 = p45 - p135;
    o.intensity = 18'(p0 + p45 + p90 + p135);
    mag2 = s1 * s1 + s2 * s2;
    q = int_sqrt(mag2 << 24) / ((s0 != 0) ? s0 : 1);
    o.dolp = (q > 65535) ? 16'hffff : 16'(q);
    o.aolp = stokes_angle(s1, s2);
    return o;
  endfunction

  // input handshake seen at the accepting edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      stokes_q.push_back(stokes_predict(in_data));
      n_sent++;
      in_taken = 1'b1;
    end
  end

  // driver: one word per accepted handshake, random gaps between words outside bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (pixel_q.size() > 0 && (in_burst || gap_len() == 0)) begin
        in_data  <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (!rst_n || out_hold) out_stall <= 1'b0;
    else out_stall <= (gap_len() != 0);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (stokes_q.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_data);
        n_errors++;
      end else begin
        out_word_t e;
        e = stokes_q.pop_front();
        n_checked++;
        if (e.intensity !== out_data.intensity)
          $display("%0t: intensity expected %0d actual %0d", $time, e.intensity,
                   out_data.intensity);
        if (e.dolp !== out_data.dolp)
          $display("%0t: dolp expected %0d actual %0d", $time, e.dolp, out_data.dolp);
        if (e.aolp !== out_data.aolp)
          $display("%0t: aolp expected %0d actual %0d", $time, e.aolp, out_data.aolp);
        if (e !== out_data) n_errors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_word_t px_make(int a, int b, int c, int d);
    in_word_t p;
    p.sample_pol90 = a;
    p.sample_pol45 = b;
    p.sample_pol135 = c;
    p.sample_pol0 = d;
    return p;
  endfunction

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hffff;
    if (r < 4) return 16'($urandom_range(0, 255));
    return 16'($urandom);
  endfunction

  // wait for the pipeline to empty, then write the mode bit
  task automatic set_mode(bit v);
    while (pixel_q.size() > 0 || in_valid || stokes_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    narrow_mode = v;
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      pixel_q.push_back(px_make(rand_sample(), rand_sample(), rand_sample(), rand_sample()));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    narrow_mode = 1'b0;
    in_burst = 1'b0;
    in_taken = 1'b0;
    out_hold = 1'b0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    cycle_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zeros, full scale, each sign of s1 and s2, axes, saturation
    pixel_q.push_back(px_make(0, 0, 0, 0));
    pixel_q.push_back(px_make(65535, 65535, 65535, 65535));
    pixel_q.push_back(px_make(0, 0, 0, 65535));
    pixel_q.push_back(px_make(65535, 0, 0, 0));
    pixel_q.push_back(px_make(0, 65535, 0, 0));
    pixel_q.push_back(px_make(0, 0, 65535, 0));
    pixel_q.push_back(px_make(100, 0, 0, 0));
    pixel_q.push_back(px_make(0, 0, 0, 100));
    pixel_q.push_back(px_make(0, 500, 0, 0));
    pixel_q.push_back(px_make(0, 0, 500, 0));
    pixel_q.push_back(px_make(0, 65535, 0, 1));
    pixel_q.push_back(px_make(1, 0, 65535, 0));
    pixel_q.push_back(px_make(100, 300, 200, 100));
    pixel_q.push_back(px_make(200, 7, 9, 100));
    pixel_q.push_back(px_make(200, 9, 7, 100));
    pixel_q.push_back(px_make(16'h5555, 16'haaaa, 16'h00ff, 16'hff00));
    pixel_q.push_back(px_make(16'haaaa, 16'h5555, 16'hff00, 16'h00ff));
    pixel_q.push_back(px_make(16'h1234, 16'h1234, 16'h1234, 16'h1234));
    add_random(450);

    set_mode(1'b1);
    pixel_q.push_back(px_make(16'hff00, 16'h01ff, 16'hff80, 16'h00ff));
    pixel_q.push_back(px_make(65535, 65535, 0, 0));
    add_random(250);

    set_mode(1'b0);
    // no stalls on either side for a stretch
    in_burst = 1'b1;
    out_hold = 1'b1;
    add_random(150);
    set_mode(1'b1);
    in_burst = 1'b0;
    out_hold = 1'b0;
    add_random(100);
    set_mode(1'b0);
    add_random(150);

    while (pixel_q.size() > 0 || in_valid || stokes_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d superpixels, checked %0d results across both sample widths",
             n_sent, n_checked);
    if (n_errors == 0 && stokes_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
